### rtl/assert_macros.svh
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle
`define CHK_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("check failed");

// implication on the next cycle
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("check failed");

`endif

### rtl/hfc_pkg.sv
package hfc_pkg;

    localparam int DW        = 32;
    localparam int FB        = 16;
    localparam int QW        = DW + FB;
    localparam int PW        = 2 * DW;
    localparam int DIV_STEPS = QW;

    localparam logic signed [DW-1:0] MAX_VAL = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] MIN_VAL = {1'b1, {(DW-1){1'b0}}};

    typedef enum logic [1:0] {
        MODE_LEFT,
        MODE_RIGHT,
        MODE_MID,
        MODE_DEGEN
    } t_mode;

    typedef struct packed {
        t_mode                  mode;
        logic signed [DW-1:0]   pass_flux;
        logic signed [DW-1:0]   pass_press;
        logic        [DW-2:0]   max_speed;
        logic                   last;
    } t_side;

    typedef struct packed {
        logic [DW-1:0] rem;
        logic [QW-1:0] dvd;
    } t_div;

    function automatic logic signed [DW-1:0] sat_sum(input logic signed [DW+1:0] v);
        if (v[DW+1:DW-1] == {3{v[DW+1]}}) begin
            return v[DW-1:0];
        end
        return v[DW+1] ? MIN_VAL : MAX_VAL;
    endfunction

    // floor of the product over 2^FB, clamped
    function automatic logic signed [DW-1:0] sat_mul(input logic signed [DW-1:0] a,
                                                     input logic signed [DW-1:0] b);
        logic signed [PW-1:0] p;
        logic signed [PW-1:0] s;
        p = PW'(a) * PW'(b);
        s = p >>> FB;
        if (s[PW-1:DW-1] == {(PW-DW+1){s[PW-1]}}) begin
            return s[DW-1:0];
        end
        return s[PW-1] ? MIN_VAL : MAX_VAL;
    endfunction

    // one restoring division step
    function automatic t_div div_step(input t_div s, input logic [DW-1:0] den);
        logic [DW:0] t;
        t_div        r;
        t = {s.rem, s.dvd[QW-1]};
        if (t >= {1'b0, den}) begin
            r.rem = DW'(t - {1'b0, den});
            r.dvd = {s.dvd[QW-2:0], 1'b1};
        end else begin
            r.rem = t[DW-1:0];
            r.dvd = {s.dvd[QW-2:0], 1'b0};
        end
        return r;
    endfunction

    // signed result from quotient magnitude, clamped
    function automatic logic signed [DW-1:0] sign_quot(input logic [QW-1:0] q,
                                                       input logic neg);
        if (neg) begin
            if (q > QW'({1'b1, {(DW-1){1'b0}}})) begin
                return MIN_VAL;
            end
            return -q[DW-1:0];
        end
        if (q > QW'(MAX_VAL)) begin
            return MAX_VAL;
        end
        return q[DW-1:0];
    endfunction

    function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
        return v[DW-1] ? DW'(-v) : DW'(v);
    endfunction

endpackage

### rtl/hfc_if.sv
interface hfc_in_if;
    logic                         valid;
    logic                         ready;
    logic signed [hfc_pkg::DW-1:0] left_speed;
    logic signed [hfc_pkg::DW-1:0] right_speed;
    logic signed [hfc_pkg::DW-1:0] left_flux;
    logic signed [hfc_pkg::DW-1:0] right_flux;
    logic signed [hfc_pkg::DW-1:0] left_cons;
    logic signed [hfc_pkg::DW-1:0] right_cons;
    logic signed [hfc_pkg::DW-1:0] left_pressure;
    logic signed [hfc_pkg::DW-1:0] right_pressure;
    logic                         last_component;

    modport source(output valid, left_speed, right_speed, left_flux, right_flux,
                   left_cons, right_cons, left_pressure, right_pressure,
                   last_component, input ready);
    modport sink(input valid, left_speed, right_speed, left_flux, right_flux,
                 left_cons, right_cons, left_pressure, right_pressure,
                 last_component, output ready);
endinterface

interface hfc_out_if;
    logic                         valid;
    logic                         ready;
    logic signed [hfc_pkg::DW-1:0] interface_flux;
    logic signed [hfc_pkg::DW-1:0] interface_pressure;
    logic        [hfc_pkg::DW-2:0] max_speed;
    logic                         degenerate;
    logic                         last_out;

    modport source(output valid, interface_flux, interface_pressure, max_speed,
                   degenerate, last_out, input ready);
    modport sink(input valid, interface_flux, interface_pressure, max_speed,
                 degenerate, last_out, output ready);
endinterface

### rtl/hll_flux_combiner_core.sv
// HLL interface flux, one component per beat. A beat is accepted every cycle
// while the output is not stalled, and its result passes through three stages
// of products and sums, one setup stage, 48 restoring divider stages (one
// quotient bit each) and the output register. When the output is stalled the
// whole pipeline holds; nothing is dropped or repeated.
`include "assert_macros.svh"

module hll_flux_combiner_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hfc_in_if.sink      i_in,
    hfc_out_if.source   o_out
);
    import hfc_pkg::*;

    logic en;
    logic r_out_valid;

    assign en         = !r_out_valid || o_out.ready;
    assign i_in.ready = en;

    // stage 1: products, difference, case selection
    logic                 r1_v;
    logic signed [DW-1:0] r1_slsr, r1_d, r1_srfl, r1_slfr, r1_srpl, r1_slpr;
    logic        [DW-1:0] r1_den;
    t_side                r1_side, n1_side;
    logic        [DW-2:0] n1_al, n1_ar;
    logic        [DW-1:0] n1_ml, n1_mr;

    always_comb begin
        n1_ml = mag(i_in.left_speed);
        n1_mr = mag(i_in.right_speed);
        n1_al = (i_in.left_speed == MIN_VAL) ? MAX_VAL[DW-2:0] : n1_ml[DW-2:0];
        n1_ar = (i_in.right_speed == MIN_VAL) ? MAX_VAL[DW-2:0] : n1_mr[DW-2:0];
        n1_side.max_speed  = (n1_al > n1_ar) ? n1_al : n1_ar;
        n1_side.last       = i_in.last_component;
        n1_side.pass_flux  = '0;
        n1_side.pass_press = '0;
        if (i_in.left_speed > 0) begin
            n1_side.mode       = MODE_LEFT;
            n1_side.pass_flux  = i_in.left_flux;
            n1_side.pass_press = i_in.left_pressure;
        end else if (i_in.right_speed < 0) begin
            n1_side.mode       = MODE_RIGHT;
            n1_side.pass_flux  = i_in.right_flux;
            n1_side.pass_press = i_in.right_pressure;
        end else if (i_in.right_speed == i_in.left_speed) begin
            n1_side.mode = MODE_DEGEN;
        end else begin
            n1_side.mode = MODE_MID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_in.valid;
        end
        if (en) begin
            r1_slsr <= sat_mul(i_in.left_speed, i_in.right_speed);
            r1_d    <= sat_sum((DW+2)'(i_in.right_cons) - (DW+2)'(i_in.left_cons));
            r1_srfl <= sat_mul(i_in.right_speed, i_in.left_flux);
            r1_slfr <= sat_mul(i_in.left_speed, i_in.right_flux);
            r1_srpl <= sat_mul(i_in.right_speed, i_in.left_pressure);
            r1_slpr <= sat_mul(i_in.left_speed, i_in.right_pressure);
            r1_den  <= DW'(i_in.right_speed - i_in.left_speed);
            r1_side <= n1_side;
        end
    end

    // stage 2: second product, pressure numerator
    logic                 r2_v;
    logic signed [DW-1:0] r2_m2, r2_srfl, r2_slfr, r2_np;
    logic        [DW-1:0] r2_den;
    t_side                r2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
        if (en) begin
            r2_m2   <= sat_mul(r1_slsr, r1_d);
            r2_srfl <= r1_srfl;
            r2_slfr <= r1_slfr;
            r2_np   <= sat_sum((DW+2)'(r1_srpl) - (DW+2)'(r1_slpr));
            r2_den  <= r1_den;
            r2_side <= r1_side;
        end
    end

    // stage 3: flux numerator
    logic                 r3_v;
    logic signed [DW-1:0] r3_nf, r3_np;
    logic        [DW-1:0] r3_den;
    t_side                r3_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= r2_v;
        end
        if (en) begin
            r3_nf   <= sat_sum((DW+2)'(r2_m2) + (DW+2)'(r2_srfl) - (DW+2)'(r2_slfr));
            r3_np   <= r2_np;
            r3_den  <= r2_den;
            r3_side <= r2_side;
        end
    end

    // stage 4 and divider chain
    logic          r_vd   [0:DIV_STEPS];
    t_div          r_df   [0:DIV_STEPS];
    t_div          r_dp   [0:DIV_STEPS];
    logic [DW-1:0] r_den  [0:DIV_STEPS];
    logic          r_negf [0:DIV_STEPS];
    logic          r_negp [0:DIV_STEPS];
    t_side         r_side [0:DIV_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd[0] <= 1'b0;
        end else if (en) begin
            r_vd[0] <= r3_v;
        end
        if (en) begin
            r_df[0]   <= '{rem: '0, dvd: {mag(r3_nf), {FB{1'b0}}}};
            r_dp[0]   <= '{rem: '0, dvd: {mag(r3_np), {FB{1'b0}}}};
            r_negf[0] <= r3_nf[DW-1];
            r_negp[0] <= r3_np[DW-1];
            r_den[0]  <= r3_den;
            r_side[0] <= r3_side;
        end
    end

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vd[g+1] <= 1'b0;
            end else if (en) begin
                r_vd[g+1] <= r_vd[g];
            end
            if (en) begin
                r_df[g+1]   <= div_step(r_df[g], r_den[g]);
                r_dp[g+1]   <= div_step(r_dp[g], r_den[g]);
                r_negf[g+1] <= r_negf[g];
                r_negp[g+1] <= r_negp[g];
                r_den[g+1]  <= r_den[g];
                r_side[g+1] <= r_side[g];
            end
        end
    end

    // output register
    t_side                s_fin;
    logic signed [DW-1:0] r_flux, r_press;
    logic        [DW-2:0] r_max;
    logic                 r_degen, r_last;

    assign s_fin = r_side[DIV_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_vd[DIV_STEPS];
        end
        if (en) begin
            r_max   <= s_fin.max_speed;
            r_last  <= s_fin.last;
            r_degen <= (s_fin.mode == MODE_DEGEN);
            if (s_fin.mode == MODE_MID) begin
                r_flux  <= sign_quot(r_df[DIV_STEPS].dvd, r_negf[DIV_STEPS]);
                r_press <= sign_quot(r_dp[DIV_STEPS].dvd, r_negp[DIV_STEPS]);
            end else begin
                r_flux  <= s_fin.pass_flux;
                r_press <= s_fin.pass_press;
            end
        end
    end

    assign o_out.valid              = r_out_valid;
    assign o_out.interface_flux     = r_flux;
    assign o_out.interface_pressure = r_press;
    assign o_out.max_speed          = r_max;
    assign o_out.degenerate         = r_degen;
    assign o_out.last_out           = r_last;

    `CHK_SAME(a_degen_zero, i_clk, i_rst_n, o_out.valid && o_out.degenerate, o_out.interface_flux == '0 && o_out.interface_pressure == '0)
    `CHK_SAME(a_rem_below_den, i_clk, i_rst_n, r_vd[DIV_STEPS] && s_fin.mode == MODE_MID, r_df[DIV_STEPS].rem < r_den[DIV_STEPS] && r_dp[DIV_STEPS].rem < r_den[DIV_STEPS])
    `CHK_NEXT(a_drain_to_out, i_clk, i_rst_n, r_vd[DIV_STEPS] && en, o_out.valid)

endmodule
